>>> design/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg: shared definitions for the sample-and-hold bit crusher
// Sample and channel types, configuration register indexes and constants.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int CHANNELS = 2;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic signed [23:0] sample_t;
  typedef logic [0:0]         channel_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_RATIO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_LEVELS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DITHER_ON    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN  = 3'd5;

  localparam logic [25:0] ONE_Q16    = 26'd65536;
  localparam logic [15:0] LFSR_SEED  = 16'hACE1;
  localparam logic [15:0] LFSR_MASK  = 16'hB400;

endpackage

>>> design/sbc_if.sv
// ----------------------------------------------------------------------------
// sbc_if: streaming channels of the sample-and-hold bit crusher
// Input channel (sample and channel number) and output channel (sample),
// both with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sbc_in_if;
  import sbc_pkg::*;

  logic     valid;
  logic     ready;
  sample_t  sample_in;
  channel_t channel;

  modport source (output valid, output sample_in, output channel, input ready);
  modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

interface sbc_out_if;
  import sbc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

>>> design/sample_hold_bit_crusher.sv
// ----------------------------------------------------------------------------
// sample_hold_bit_crusher: sample-rate reducer and bit-depth crusher
// Per-channel fractional sample-and-hold, quantization with optional
// uniform dither, wet/dry mix and output gain with saturation.
// ----------------------------------------------------------------------------
//
//  Port      Dir   Handshake       Payload
//  in_chan   in    valid/ready     sample_in (s24 Q1.23), channel (u1)
//  out_chan  out   valid/ready     sample_out (s24 Q1.23)
//  cfg_*     in    cfg_we only     cfg_index (3 bits), cfg_data (32 bits)
//
// Every product goes through the single 33 x 25 bit multiplier in turn:
// two multiplications with quantization bypassed, five without dither and
// six with it, which the sequencer steps through together with their add,
// round and clamp steps before the result register is loaded. The input is
// ready again in the cycle after the result register is loaded.
// The input is not ready while a transaction is being worked on.
// The finished result sits in an output register, so the next transaction
// can be accepted while it waits; a stalled output holds the sequencer in
// its last step. Reset is synchronous and needs no clearing pass.
module sample_hold_bit_crusher (
  input  logic                           clk,
  input  logic                           rst,
  sbc_in_if.sink                         in_chan,
  sbc_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [sbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sbc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HOLD = 4'd1;
  localparam logic [3:0] S_DMUL = 4'd2;
  localparam logic [3:0] S_DADD = 4'd3;
  localparam logic [3:0] S_LO   = 4'd4;
  localparam logic [3:0] S_HI   = 4'd5;
  localparam logic [3:0] S_SUM  = 4'd6;
  localparam logic [3:0] S_ABS  = 4'd7;
  localparam logic [3:0] S_RND  = 4'd8;
  localparam logic [3:0] S_QMUL = 4'd9;
  localparam logic [3:0] S_CLMP = 4'd10;
  localparam logic [3:0] S_MIX  = 4'd11;
  localparam logic [3:0] S_ACC  = 4'd12;
  localparam logic [3:0] S_GAIN = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  function automatic sample_t sat24(input logic signed [57:0] v);
    if (v > 58'sd8388607) begin
      return 24'sh7FFFFF;
    end
    if (v < -58'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  // Configuration registers
  logic [25:0] hold_ratio;
  logic [23:0] quant_step;
  logic [31:0] quant_levels;
  logic        dither_on;
  logic [8:0]  wet_mix;
  logic [15:0] output_gain;

  // Channel state
  logic [25:0] hold_phase  [CHANNELS];
  sample_t     held_sample [CHANNELS];
  logic [15:0] lfsr;

  // Sequencer and datapath registers
  logic [3:0]         state;
  sample_t            dry;
  logic [CH_W-1:0]    ch;
  sample_t            wet;
  logic signed [25:0] x;
  logic signed [57:0] p;
  logic [57:0]        mag;
  logic               neg;
  logic signed [27:0] n;
  logic signed [57:0] prod;
  logic signed [32:0] acc;
  logic               out_valid;
  sample_t            out_data;

  // Combinational helpers
  logic [CH_W-1:0]    ch_sel;
  logic [26:0]        phase_sum;
  logic               latch;
  logic [26:0]        phase_next;
  sample_t            wet_next;
  logic [15:0]        lfsr_next;
  logic [8:0]         wet_w;
  logic signed [24:0] diff;
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic               mul_en;
  logic signed [57:0] dith_shift;
  logic [57:0]        mag_sum;
  logic [26:0]        rnd;
  logic signed [32:0] acc_sum;
  logic signed [57:0] out_round;
  logic signed [57:0] out_shift;
  logic               bypass_rate;
  logic               bypass_depth;
  logic               out_free;

  assign in_chan.ready       = (state == S_IDLE);
  assign out_chan.valid      = out_valid;
  assign out_chan.sample_out = out_data;

  assign ch_sel = (32'(in_chan.channel) > CHANNELS - 1) ? CH_W'(CHANNELS - 1)
                                                        : CH_W'(in_chan.channel);

  assign bypass_rate  = ({6'd0, hold_ratio} <= 32'd65536);
  assign bypass_depth = (quant_step <= 24'd1);
  assign out_free     = !out_valid || out_chan.ready;

  // Hold phase update for the channel of the current transaction.
  assign phase_sum  = {1'b0, hold_phase[ch]} + {1'b0, ONE_Q16};
  assign latch      = (phase_sum >= {1'b0, hold_ratio});
  assign phase_next = latch ? (phase_sum - {1'b0, hold_ratio}) : phase_sum;
  assign wet_next   = bypass_rate ? dry : (latch ? dry : held_sample[ch]);

  always_comb begin
    lfsr_next = {1'b0, lfsr[15:1]};
    if (lfsr[0]) begin
      lfsr_next = lfsr_next ^ LFSR_MASK;
    end
    if (lfsr_next == 16'd0) begin
      lfsr_next = LFSR_SEED;
    end
  end

  assign wet_w = (wet_mix > 9'd256) ? 9'd256 : wet_mix;
  assign diff  = {wet[23], wet} - {dry[23], dry};

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (state)
      S_DMUL: begin
        // r - 32768 for r in 1..65535 is r with its top bit flipped, signed.
        mul_a = 33'($signed(lfsr_next ^ 16'h8000));
        mul_b = $signed({1'b0, quant_step});
      end
      S_LO: begin
        mul_a = 33'(x);
        mul_b = $signed({9'd0, quant_levels[15:0]});
      end
      S_HI: begin
        mul_a = 33'(x);
        mul_b = $signed({9'd0, quant_levels[31:16]});
      end
      S_QMUL: begin
        mul_a = 33'(n);
        mul_b = $signed({1'b0, quant_step});
      end
      S_MIX: begin
        mul_a = 33'(diff);
        mul_b = $signed({16'd0, wet_w});
      end
      S_GAIN: begin
        mul_a = acc;
        mul_b = $signed({9'd0, output_gain});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign dith_shift = prod >>> 17;
  assign mag_sum    = mag + (58'd1 << 30);
  assign rnd        = mag_sum[57:31];
  // The mixed sum always fits 32 bits signed, so the wrap at 33 bits is exact.
  assign acc_sum    = 33'($signed({dry, 8'd0})) + prod[32:0];
  assign out_round  = prod + 58'sd524288;
  assign out_shift  = out_round >>> 20;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end

    case (state)
      S_IDLE: begin
        if (in_chan.valid) begin
          dry <= in_chan.sample_in;
          ch  <= ch_sel;
        end
      end
      S_HOLD: begin
        wet <= wet_next;
        x   <= 26'(wet_next);
      end
      S_DADD: begin
        x <= 26'(wet) + dith_shift[25:0];
      end
      S_HI: begin
        p <= prod;
      end
      S_SUM: begin
        p <= p + $signed({prod[41:0], 16'd0});
      end
      S_ABS: begin
        neg <= p[57];
        mag <= p[57] ? 58'(-p) : 58'(p);
      end
      S_RND: begin
        n <= neg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
      end
      S_CLMP: begin
        wet <= sat24(prod);
      end
      S_ACC: begin
        acc <= acc_sum;
      end
      S_OUT: begin
        if (out_free) begin
          out_data <= sat24(out_shift);
        end
      end
      default: begin
      end
    endcase

    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      hold_ratio   <= 26'd65536;
      quant_step   <= 24'd256;
      quant_levels <= 32'd8388608;
      dither_on    <= 1'b0;
      wet_mix      <= 9'd256;
      output_gain  <= 16'd4096;
      lfsr         <= LFSR_SEED;
      for (int i = 0; i < CHANNELS; i++) begin
        hold_phase[i]  <= '0;
        held_sample[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HOLD_RATIO:   hold_ratio   <= cfg_data[25:0];
          REG_QUANT_STEP:   quant_step   <= cfg_data[23:0];
          REG_QUANT_LEVELS: quant_levels <= cfg_data[31:0];
          REG_DITHER_ON:    dither_on    <= cfg_data[0];
          REG_WET_MIX:      wet_mix      <= cfg_data[8:0];
          REG_OUTPUT_GAIN:  output_gain  <= cfg_data[15:0];
          default: begin
          end
        endcase
      end

      // A new result replaces one that leaves in the same cycle.
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_chan.valid) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!bypass_rate) begin
            hold_phase[ch] <= phase_next[25:0];
            if (latch) begin
              held_sample[ch] <= dry;
            end
          end
          if (bypass_depth) begin
            state <= S_MIX;
          end else if (dither_on) begin
            state <= S_DMUL;
          end else begin
            state <= S_LO;
          end
        end
        S_DMUL: begin
          lfsr  <= lfsr_next;
          state <= S_DADD;
        end
        S_DADD: state <= S_LO;
        S_LO:   state <= S_HI;
        S_HI:   state <= S_SUM;
        S_SUM:  state <= S_ABS;
        S_ABS:  state <= S_RND;
        S_RND:  state <= S_QMUL;
        S_QMUL: state <= S_CLMP;
        S_CLMP: state <= S_MIX;
        S_MIX:  state <= S_ACC;
        S_ACC:  state <= S_GAIN;
        S_GAIN: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
